// ===== hdl/rolling_hash_pattern_matcher_unit_defines.svh =====
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher_unit_defines
// assertion macros used by the matcher rtl
// ----------------------------------------------------------------------------
`ifndef ROLLING_HASH_PATTERN_MATCHER_UNIT_DEFINES_SVH
`define ROLLING_HASH_PATTERN_MATCHER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RHPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RHPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rhpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rhpm_pkg
// shared types and constants of the rolling hash pattern matcher
// ----------------------------------------------------------------------------
`default_nettype none

package rhpm_pkg;

  localparam int HASH_W = 64;
  localparam int SYM_W  = 8;

  // 2^64 - 59
  localparam logic [HASH_W-1:0] HASH_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

  localparam int MAX_PATTERN_DEF   = 64;
  localparam int POSITION_BITS_DEF = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2
  } cmd_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

`default_nettype wire

// ===== hdl/rhpm_mod_alu.sv =====
// ----------------------------------------------------------------------------
// rhpm_mod_alu
// modular add / subtract over the hash prime, operands already reduced
// ----------------------------------------------------------------------------
`default_nettype none

module rhpm_mod_alu (
  input  rhpm_pkg::alu_op_t            op,
  input  logic [rhpm_pkg::HASH_W-1:0]  a,
  input  logic [rhpm_pkg::HASH_W-1:0]  b,
  output logic [rhpm_pkg::HASH_W-1:0]  y
);

  logic [rhpm_pkg::HASH_W:0] sum;
  logic [rhpm_pkg::HASH_W:0] prime_ext;

  assign prime_ext = {1'b0, rhpm_pkg::HASH_PRIME};

  always_comb begin
    sum = '0;
    y   = '0;
    case (op)
      rhpm_pkg::ALU_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        // sum stays below twice the prime
        if (sum >= prime_ext) begin
          sum = sum - prime_ext;
        end
        y = sum[rhpm_pkg::HASH_W-1:0];
      end
      rhpm_pkg::ALU_SUB: begin
        if (a >= b) begin
          y = a - b;
        end else begin
          y = a - b + rhpm_pkg::HASH_PRIME;
        end
      end
      default: begin
        y = a;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/rolling_hash_pattern_matcher_unit.sv =====
// sequencing: a pattern byte runs the power update (not for the first byte), scale and add;
//   a text byte runs load, multiply and subtract (once the window is full), scale, add, check,
//   then a read and compare per pattern byte to verify a hash hit, and emit of the match
// one transaction at a time, input stalled while busy; the multiply does one modular add per cycle
// reset: synchronous active low, clears hashes, counts and pointers; memories keep contents
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher_unit
// streaming rabin-karp matcher with pattern and text window in synchronous memories
// ----------------------------------------------------------------------------
`default_nettype none

`include "rolling_hash_pattern_matcher_unit_defines.svh"

module rolling_hash_pattern_matcher_unit #(
  parameter int MAX_PATTERN   = rhpm_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = rhpm_pkg::POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_command,
  input  logic [7:0]               in_symbol,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [POSITION_BITS-1:0] out_match_position
);

  localparam int HW = rhpm_pkg::HASH_W;
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int SW = AW + 2;
  localparam int PB = POSITION_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TP,
    S_LOAD,
    S_MUL,
    S_SUB,
    S_SCALE,
    S_ADD,
    S_CHK,
    S_VRD,
    S_VCMP,
    S_EMIT
  } state_t;

  state_t            state_r;
  rhpm_pkg::cmd_t    cmd_r;
  logic [7:0]        sym_r;
  logic              step_r;
  logic [2:0]        bit_r;
  logic [7:0]        byte_r;
  logic [HW-1:0]     acc_r;
  logic [HW-1:0]     ph_r;
  logic [HW-1:0]     wh_r;
  logic [HW-1:0]     tp_r;
  logic [LW-1:0]     plen_r;
  logic [PB-1:0]     tcount_r;
  logic [PB-1:0]     index_r;
  logic [AW-1:0]     ring_r;
  logic [AW-1:0]     vslot_r;
  logic [AW-1:0]     vj_r;
  logic              out_valid_r;
  logic [PB-1:0]     out_pos_r;

  // symbol memories
  logic [7:0]        pat_mem [MAX_PATTERN];
  logic [7:0]        win_mem [MAX_PATTERN];
  logic [7:0]        pat_q_r;
  logic [7:0]        win_q_r;
  logic              pat_we;
  logic              win_we;
  logic [AW-1:0]     win_ra;

  rhpm_pkg::alu_op_t alu_op;
  logic [HW-1:0]     alu_a;
  logic [HW-1:0]     alu_b;
  logic [HW-1:0]     alu_y;

  logic              in_fire;
  rhpm_pkg::cmd_t    in_cmd;
  logic [AW-1:0]     old_slot;
  logic [PB:0]       next_index;
  logic [PB:0]       pos_full;

  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] p,
                                               input logic [LW-1:0] n);
    logic [SW-1:0] t;
    t = SW'(p) + SW'(MAX_PATTERN) - SW'(n);
    if (t >= SW'(MAX_PATTERN)) begin
      t = t - SW'(MAX_PATTERN);
    end
    return t[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    logic [SW-1:0] t;
    t = SW'(p) + SW'(1);
    if (t >= SW'(MAX_PATTERN)) begin
      t = '0;
    end
    return t[AW-1:0];
  endfunction

  assign in_stall           = (state_r != S_IDLE);
  assign in_fire            = in_valid && !in_stall;
  assign in_cmd             = rhpm_pkg::cmd_t'(in_command);
  assign out_valid          = out_valid_r;
  assign out_match_position = out_pos_r;

  assign old_slot   = ring_back(ring_r, plen_r);
  assign next_index = {1'b0, index_r} + (PB+1)'(1);
  assign pos_full   = next_index - (PB+1)'(plen_r);

  assign pat_we = in_fire && (in_cmd == rhpm_pkg::CMD_PATTERN) &&
                  (tcount_r == '0) && (plen_r < LW'(MAX_PATTERN));
  assign win_we = (state_r == S_ADD) && (cmd_r == rhpm_pkg::CMD_TEXT);
  // idle reads the byte leaving the window, verify reads the window slot
  assign win_ra = (state_r == S_IDLE) ? old_slot : vslot_r;

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[plen_r[AW-1:0]] <= in_symbol;
    end
    pat_q_r <= pat_mem[vj_r];
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[ring_r] <= sym_r;
    end
    win_q_r <= win_mem[win_ra];
  end

  always_comb begin
    alu_op = rhpm_pkg::ALU_ADD;
    alu_a  = acc_r;
    alu_b  = acc_r;
    case (state_r)
      S_TP: begin
        alu_a = tp_r;
        alu_b = tp_r;
      end
      S_MUL: begin
        if (step_r) begin
          alu_b = tp_r;
        end
      end
      S_SUB: begin
        alu_op = rhpm_pkg::ALU_SUB;
        alu_a  = wh_r;
        alu_b  = acc_r;
      end
      S_ADD: begin
        alu_b = {{(HW-8){1'b0}}, sym_r};
      end
      default: begin
        alu_op = rhpm_pkg::ALU_ADD;
      end
    endcase
  end

  rhpm_mod_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= rhpm_pkg::CMD_CLEAR;
      step_r      <= 1'b0;
      bit_r       <= '0;
      ph_r        <= '0;
      wh_r        <= '0;
      tp_r        <= HW'(1);
      plen_r      <= '0;
      tcount_r    <= '0;
      ring_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // emit handles its own output handoff
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r  <= in_cmd;
            sym_r  <= in_symbol;
            step_r <= 1'b0;
            case (in_cmd)
              rhpm_pkg::CMD_CLEAR: begin
                ph_r     <= '0;
                wh_r     <= '0;
                tp_r     <= HW'(1);
                plen_r   <= '0;
                tcount_r <= '0;
                ring_r   <= '0;
              end
              rhpm_pkg::CMD_PATTERN: begin
                if (pat_we) begin
                  acc_r  <= ph_r;
                  plen_r <= plen_r + LW'(1);
                  state_r <= (plen_r != '0) ? S_TP : S_SCALE;
                end
              end
              rhpm_pkg::CMD_TEXT: begin
                index_r <= tcount_r;
                if ((plen_r != '0) && (tcount_r >= PB'(plen_r))) begin
                  state_r <= S_LOAD;
                end else begin
                  acc_r   <= wh_r;
                  state_r <= S_SCALE;
                end
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_TP: begin
          tp_r   <= alu_y;
          step_r <= !step_r;
          if (step_r) begin
            state_r <= S_SCALE;
          end
        end
        S_LOAD: begin
          byte_r  <= win_q_r;
          acc_r   <= '0;
          bit_r   <= 3'd7;
          step_r  <= 1'b0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          // per bit, msb first: double, then add the power when the bit is set
          acc_r <= alu_y;
          if (!step_r && byte_r[bit_r]) begin
            step_r <= 1'b1;
          end else begin
            step_r <= 1'b0;
            if (bit_r == 3'd0) begin
              state_r <= S_SUB;
            end else begin
              bit_r <= bit_r - 3'd1;
            end
          end
        end
        S_SUB: begin
          acc_r   <= alu_y;
          step_r  <= 1'b0;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          // times four as two doublings
          acc_r  <= alu_y;
          step_r <= !step_r;
          if (step_r) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (cmd_r == rhpm_pkg::CMD_PATTERN) begin
            ph_r    <= alu_y;
            state_r <= S_IDLE;
          end else begin
            wh_r   <= alu_y;
            ring_r <= ring_inc(ring_r);
            if (tcount_r != '1) begin
              tcount_r <= tcount_r + PB'(1);
            end
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          vj_r    <= '0;
          vslot_r <= ring_back(ring_r, plen_r);
          if ((plen_r == '0) || (next_index < (PB+1)'(plen_r)) || (wh_r != ph_r)) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_VRD;
          end
        end
        S_VRD: begin
          state_r <= S_VCMP;
        end
        S_VCMP: begin
          if (pat_q_r != win_q_r) begin
            state_r <= S_IDLE;
          end else if ((LW'(vj_r) + LW'(1)) == plen_r) begin
            state_r <= S_EMIT;
          end else begin
            vj_r    <= vj_r + AW'(1);
            vslot_r <= ring_inc(vslot_r);
            state_r <= S_VRD;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= pos_full[PB-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `RHPM_ASSERT_NOW(a_busy_stalls, state_r != S_IDLE, in_stall, "input taken while busy")
  `RHPM_ASSERT_NOW(a_plen_range, 1'b1, plen_r <= LW'(MAX_PATTERN), "pattern length overflow")
  `RHPM_ASSERT_NOW(a_ring_range, 1'b1, SW'(ring_r) < SW'(MAX_PATTERN), "ring pointer out of range")
  `RHPM_ASSERT_NEXT(a_emit_loads, (state_r == S_EMIT) && !(out_valid_r && out_stall), out_valid_r, "match not presented")

endmodule

`default_nettype wire

// ===== tb/tb_rolling_hash_pattern_matcher_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rolling_hash_pattern_matcher_unit
// drives clear, pattern, text and unused-command transactions into the streaming matcher,
// predicts every match start position with a local modular-hash model, and
// compares each result transaction in order under random gaps and stalls
// ----------------------------------------------------------------------------

module tb_rolling_hash_pattern_matcher_unit;

  localparam int MAXP         = rhpm_pkg::MAX_PATTERN_DEF;
  localparam int POS_W        = rhpm_pkg::POSITION_BITS_DEF;
  localparam logic [63:0] HASH_BASE = 64'd4;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_LIMIT   = 5000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_command = rhpm_pkg::CMD_CLEAR;
  logic [7:0]       in_symbol = 8'd0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [POS_W-1:0] out_match_position;

  // matcher prediction state
  logic [7:0]       pat_mem [MAXP];
  logic [7:0]       text_ring [MAXP];
  int unsigned      pat_len = 0;
  int unsigned      ring_wr = 0;
  logic [63:0]      pat_hash = '0;
  logic [63:0]      win_hash = '0;
  logic [63:0]      lead_power = 64'd1;
  logic [POS_W-1:0] text_cnt = '0;

  logic [POS_W-1:0] expected_starts [$];
  logic [POS_W-1:0] next_start;
  int               errors = 0;
  int               work_items = 0;
  int               idle_cycles = 0;
  bit               steady = 1'b0;
  bit               receiver_hold = 1'b0;

  rolling_hash_pattern_matcher_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_symbol          (in_symbol),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_match_position (out_match_position)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, rhpm_pkg::HASH_PRIME});
  endfunction

  function automatic logic [63:0] add_mod(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, rhpm_pkg::HASH_PRIME}) s = s - {1'b0, rhpm_pkg::HASH_PRIME};
    return s[63:0];
  endfunction

  function automatic logic [63:0] sub_mod(input logic [63:0] a, input logic [63:0] b);
    return (a >= b) ? (a - b) : (a - b + rhpm_pkg::HASH_PRIME);
  endfunction

  function automatic void restart_search();
    pat_len    = 0;
    ring_wr    = 0;
    pat_hash   = '0;
    win_hash   = '0;
    lead_power = 64'd1;
    text_cnt   = '0;
  endfunction

  // updates the search state for one accepted transaction, queues a match start on a verified hit
  function automatic void advance_matcher(input logic [1:0] cmd, input logic [7:0] sym);
    logic [63:0] idx;
    logic [7:0]  old_sym;
    bit          hit;
    case (cmd)
      rhpm_pkg::CMD_CLEAR: begin
        restart_search();
      end
      rhpm_pkg::CMD_PATTERN: begin
        if (text_cnt == 0 && pat_len < MAXP) begin
          if (pat_len > 0) lead_power = mul_mod(lead_power, HASH_BASE);
          pat_hash = add_mod(mul_mod(pat_hash, HASH_BASE), {56'd0, sym});
          pat_mem[pat_len] = sym;
          pat_len++;
        end
      end
      rhpm_pkg::CMD_TEXT: begin
        idx = 64'(text_cnt);
        if (pat_len > 0 && idx >= pat_len) begin
          old_sym  = text_ring[(ring_wr + MAXP - pat_len) % MAXP];
          win_hash = sub_mod(win_hash, mul_mod(lead_power, {56'd0, old_sym}));
        end
        win_hash = add_mod(mul_mod(win_hash, HASH_BASE), {56'd0, sym});
        text_ring[ring_wr] = sym;
        ring_wr = (ring_wr + 1) % MAXP;
        if (text_cnt != '1) text_cnt++;
        if (pat_len != 0 && idx + 1 >= pat_len && win_hash == pat_hash) begin
          hit = 1'b1;
          for (int j = 0; j < pat_len; j++)
            if (text_ring[(ring_wr + MAXP - pat_len + j) % MAXP] != pat_mem[j]) hit = 1'b0;
          if (hit) expected_starts.insert(expected_starts.size(), POS_W'(idx + 1 - pat_len));
        end
      end
      default: ;
    endcase
  endfunction

  // mostly short pauses, a few long ones
  function automatic int unsigned pick_pause();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] sym);
    int unsigned gap;
    gap = pick_pause();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    in_command = cmd;
    in_symbol  = sym;
    do @(posedge clk); while (in_stall);
    advance_matcher(cmd, sym);
    if (cmd != CMD_UNUSED) work_items++;
  endtask

  task automatic send_pattern(input logic [7:0] bytes[$]);
    foreach (bytes[k]) send_item(rhpm_pkg::CMD_PATTERN, bytes[k]);
  endtask

  task automatic send_text(input logic [7:0] bytes[$]);
    foreach (bytes[k]) send_item(rhpm_pkg::CMD_TEXT, bytes[k]);
  endtask

  // result side: random stalls, or one long hold when asked
  initial begin
    int unsigned len;
    forever begin
      @(negedge clk);
      if (receiver_hold) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        receiver_hold = 1'b0;
      end else if (steady || $urandom_range(0, 99) < 65) begin
        out_stall = 1'b0;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        out_stall = 1'b1;
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_starts.size() == 0) begin
        $display("%0t: unexpected match: expected none, actual %0d", $time,
                 out_match_position);
        errors++;
      end else begin
        next_start = expected_starts.pop_front();
        if (out_match_position !== next_start) begin
          $display("%0t: match_position mismatch: expected %0d, actual %0d", $time,
                   next_start, out_match_position);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("tb_rolling_hash_pattern_matcher_unit failed");
        $finish;
      end
    end
  end

  // extremes of the symbol range, adjacent matches of a one-byte pattern
  task automatic test_basic_match();
    send_item(rhpm_pkg::CMD_CLEAR, 8'hFF);
    send_pattern('{8'h00, 8'hFF});
    send_text('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00});
    send_item(rhpm_pkg::CMD_CLEAR, 8'h00);
    send_pattern('{8'hFF});
    send_text('{8'hFF, 8'hFF, 8'h00});
  endtask

  // late pattern byte, unused command, text with no pattern
  task automatic test_special_commands();
    send_item(rhpm_pkg::CMD_CLEAR, 8'h00);
    send_pattern('{8'h5A});
    send_text('{8'h5A});
    send_item(rhpm_pkg::CMD_PATTERN, 8'h33);
    send_text('{8'h5A});
    send_item(CMD_UNUSED, 8'h5A);
    send_item(CMD_UNUSED, 8'hA5);
    send_text('{8'h5A});
    send_item(rhpm_pkg::CMD_CLEAR, 8'hAA);
    send_text('{8'h12, 8'h00, 8'hFF});
  endtask

  // full-size periodic pattern plus bytes past the store, matched with overlaps
  task automatic test_long_pattern();
    logic [7:0] block [8];
    logic [7:0] bytes [$];
    foreach (block[k]) block[k] = 8'($urandom_range(0, 255));
    send_item(rhpm_pkg::CMD_CLEAR, 8'h00);
    for (int k = 0; k < MAXP; k++) bytes.insert(bytes.size(), block[k % 8]);
    send_pattern(bytes);
    send_pattern('{~block[0], ~block[1], ~block[2]});
    bytes.delete();
    repeat (5) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
    for (int k = 0; k < MAXP + 16; k++) bytes.insert(bytes.size(), block[k % 8]);
    send_text(bytes);
  endtask

  // long receiver hold while every text byte matches, so the block backs up
  task automatic test_backpressure();
    steady = 1'b1;
    send_item(rhpm_pkg::CMD_CLEAR, 8'h00);
    send_pattern('{8'h41});
    receiver_hold = 1'b1;
    repeat (40) send_item(rhpm_pkg::CMD_TEXT, 8'h41);
    @(negedge clk);
    in_valid = 1'b0;
    while (receiver_hold) @(posedge clk);
    steady = 1'b0;
  endtask

  task automatic test_random_search();
    logic [7:0]  alphabet [4];
    logic [7:0]  pat [$];
    int unsigned nsym, plen, tlen, r;
    while (work_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) steady = ~steady;
      if ($urandom_range(0, 99) < 85) begin
        foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(0, 255));
        nsym = $urandom_range(1, 4);
        r = $urandom_range(0, 99);
        plen = (r < 80) ? $urandom_range(1, 6) :
               (r < 96) ? $urandom_range(7, 20) : $urandom_range(60, 68);
        pat.delete();
        repeat (plen) pat.insert(pat.size(), alphabet[$urandom_range(0, nsym - 1)]);
        send_item(rhpm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
        send_pattern(pat);
        tlen = $urandom_range(10, 50);
        for (int k = 0; k < tlen; k++) begin
          if ($urandom_range(0, 29) == 0)
            send_item(rhpm_pkg::CMD_PATTERN, 8'($urandom_range(0, 255)));
          else if ($urandom_range(0, 19) == 0)
            send_item(rhpm_pkg::CMD_TEXT, 8'($urandom_range(0, 255)));
          else
            send_item(rhpm_pkg::CMD_TEXT, alphabet[$urandom_range(0, nsym - 1)]);
        end
        // plant the pattern so longer ones still hit
        if ($urandom_range(0, 1) == 0) send_text(pat);
      end else begin
        repeat ($urandom_range(5, 15))
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_basic_match();
    test_special_commands();
    test_long_pattern();
    test_backpressure();
    work_items = 0;
    test_random_search();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_starts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_starts.size() == 0) begin
      $display("tb_rolling_hash_pattern_matcher_unit passed");
    end else begin
      $display("tb_rolling_hash_pattern_matcher_unit failed");
    end
    $finish;
  end

endmodule
